### rtl/core/bar_pkg.sv
// ----------------------------------------------------------------------------
// bar_pkg
// Shared sizes, codes, types and helpers of the box-average resampler core.
// ----------------------------------------------------------------------------
`default_nettype none

package bar_pkg;

    localparam int MAX_SRC_WIDTH  = 256;
    localparam int MAX_SRC_HEIGHT = 256;
    localparam int MAX_DST_DIM    = 1024;

    localparam int COORD_W     = 10;
    localparam int CH_W        = 8;
    localparam int SRC_SIZE_W  = 9;
    localparam int DST_SIZE_W  = 11;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 2;

    localparam int SRC_COL_W  = $clog2(MAX_SRC_WIDTH);
    localparam int SRC_ROW_W  = $clog2(MAX_SRC_HEIGHT);
    localparam int ADDR_W     = $clog2(MAX_SRC_WIDTH * MAX_SRC_HEIGHT);
    localparam int STORE_DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;

    localparam int CNT_W      = SRC_SIZE_W;
    localparam int PIX_CNT_W  = $clog2(MAX_SRC_WIDTH * MAX_SRC_HEIGHT + 1);
    localparam int SUM_W      = CH_W + $clog2(MAX_SRC_WIDTH * MAX_SRC_HEIGHT);
    localparam int PROD_W     = DST_SIZE_W + SRC_SIZE_W;
    localparam int DVD_W      = (SUM_W > PROD_W) ? SUM_W : PROD_W;
    localparam int DSR_W      = (PIX_CNT_W > DST_SIZE_W) ? PIX_CNT_W : DST_SIZE_W;
    localparam int Q_W        = SRC_SIZE_W;
    localparam int DIV_STEP_W = $clog2(Q_W + 1);

    localparam logic FUNC_LOAD    = 1'b0;
    localparam logic FUNC_REQUEST = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] CFG_SRC_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SRC_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DST_WIDTH  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DST_HEIGHT = 2'd3;

    localparam int DIV_SEL_W = 3;
    localparam logic [DIV_SEL_W-1:0] DIV_FX    = 3'd0;
    localparam logic [DIV_SEL_W-1:0] DIV_FX2   = 3'd1;
    localparam logic [DIV_SEL_W-1:0] DIV_FY    = 3'd2;
    localparam logic [DIV_SEL_W-1:0] DIV_FY2   = 3'd3;
    localparam logic [DIV_SEL_W-1:0] DIV_RED   = 3'd4;
    localparam logic [DIV_SEL_W-1:0] DIV_GREEN = 3'd5;
    localparam logic [DIV_SEL_W-1:0] DIV_BLUE  = 3'd6;

    typedef struct packed {
        logic                 load;
        logic                 emit_err;
        logic                 latch;
        logic                 mul;
        logic                 div_start;
        logic                 div_capture;
        logic [DIV_SEL_W-1:0] div_sel;
        logic                 win;
        logic                 prep;
        logic                 walk;
        logic                 emit;
    } bar_cmd_t;

    typedef struct packed {
        logic req_err;
        logic div_busy;
        logic walk_last;
    } bar_stat_t;

    function automatic logic [CFG_DATA_W-1:0] clamp_size(
        input logic [CFG_DATA_W-1:0] v,
        input logic [CFG_DATA_W-1:0] limit
    );
        logic [CFG_DATA_W-1:0] r;
        if (v == '0)
        begin
            r = CFG_DATA_W'(1);
        end
        else if (v > limit)
        begin
            r = limit;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/core/box_average_image_resampler_core.sv
// ----------------------------------------------------------------------------
// box_average_image_resampler_core
// Frame store with box-average readout of a resized RGB image.
// ----------------------------------------------------------------------------
// A transfer is taken when start is high and busy is low. A load (func 0)
// writes one source pixel in that cycle, if inside the source size, and gives
// no result; busy stays low. A request (func 1) outside the target size gives
// its result (zero colour, range_error set) on the next cycle, again without
// raising busy. Any other request holds busy while its source window, cx by
// cy pixels, is found, walked and averaged; its result is shown for one cycle,
// marked by done, as busy drops. Seven divisions go through one shared divider
// that yields one quotient bit per cycle, and the window walk reads one
// pixel per cycle through the single read port of the frame store. Results
// cannot be held off, so done must be taken in the cycle it is high.
// ----------------------------------------------------------------------------
`default_nettype none

module box_average_image_resampler_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic                            func,
    input  wire logic [bar_pkg::COORD_W-1:0]     pos_col,
    input  wire logic [bar_pkg::COORD_W-1:0]     pos_row,
    input  wire logic [bar_pkg::CH_W-1:0]        in_red,
    input  wire logic [bar_pkg::CH_W-1:0]        in_green,
    input  wire logic [bar_pkg::CH_W-1:0]        in_blue,
    input  wire logic                            cfg_write,
    input  wire logic [bar_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [bar_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                                 done,
    output logic [bar_pkg::CH_W-1:0]             out_red,
    output logic [bar_pkg::CH_W-1:0]             out_green,
    output logic [bar_pkg::CH_W-1:0]             out_blue,
    output logic                                 range_error
);

    bar_pkg::bar_cmd_t  cmd;
    bar_pkg::bar_stat_t stat;

    bar_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .func  (func),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    bar_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pos_col     (pos_col),
        .pos_row     (pos_row),
        .in_red      (in_red),
        .in_green    (in_green),
        .in_blue     (in_blue),
        .done        (done),
        .out_red     (out_red),
        .out_green   (out_green),
        .out_blue    (out_blue),
        .range_error (range_error)
    );

endmodule

`default_nettype wire

### rtl/core/bar_div.sv
// ----------------------------------------------------------------------------
// bar_div
// Restoring divider, one quotient bit per cycle, quotient known to fit Q_W.
// ----------------------------------------------------------------------------
`default_nettype none

module bar_div (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [bar_pkg::DVD_W-1:0] dividend,
    input  wire logic [bar_pkg::DSR_W-1:0] divisor,
    output logic                           busy,
    output logic [bar_pkg::Q_W-1:0]        quotient
);

    logic [bar_pkg::DIV_STEP_W-1:0] cnt_reg;
    logic [bar_pkg::DSR_W-1:0]      rem_reg;
    logic [bar_pkg::DSR_W-1:0]      rem_next;
    logic [bar_pkg::DSR_W-1:0]      dsr_reg;
    logic [bar_pkg::Q_W-1:0]        dvd_reg;
    logic [bar_pkg::Q_W-1:0]        quo_reg;
    logic [bar_pkg::DSR_W:0]        trial;
    logic                           ge;

    always_comb
    begin
        trial    = {rem_reg, dvd_reg[bar_pkg::Q_W-1]};
        ge       = (trial >= {1'b0, dsr_reg});
        rem_next = ge ? bar_pkg::DSR_W'(trial - {1'b0, dsr_reg})
                      : bar_pkg::DSR_W'(trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= bar_pkg::DIV_STEP_W'(bar_pkg::Q_W);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - bar_pkg::DIV_STEP_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= bar_pkg::DSR_W'(dividend[bar_pkg::DVD_W-1:bar_pkg::Q_W]);
            dvd_reg <= dividend[bar_pkg::Q_W-1:0];
            dsr_reg <= divisor;
            quo_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[bar_pkg::Q_W-2:0], 1'b0};
            quo_reg <= {quo_reg[bar_pkg::Q_W-2:0], ge};
        end
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = quo_reg;

endmodule

`default_nettype wire

### rtl/core/bar_ctrl.sv
// ----------------------------------------------------------------------------
// bar_ctrl
// Sequencer: divisions for the window, window walk, channel divisions.
// ----------------------------------------------------------------------------
`default_nettype none

module bar_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic                func,
    input  wire bar_pkg::bar_stat_t  stat,
    output bar_pkg::bar_cmd_t        cmd,
    output logic                     busy
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_DWAIT = 3'd3;
    localparam logic [2:0] S_WIN   = 3'd4;
    localparam logic [2:0] S_PREP  = 3'd5;
    localparam logic [2:0] S_WALK  = 3'd6;
    localparam logic [2:0] S_DRAIN = 3'd7;

    logic [2:0]                    state_reg;
    logic [2:0]                    state_next;
    logic [bar_pkg::DIV_SEL_W-1:0] sel_reg;
    logic [bar_pkg::DIV_SEL_W-1:0] sel_next;

    always_comb
    begin
        cmd         = '0;
        cmd.div_sel = sel_reg;
        state_next  = state_reg;
        sel_next    = sel_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (func == bar_pkg::FUNC_LOAD)
                    begin
                        cmd.load = 1'b1;
                    end
                    else if (stat.req_err)
                    begin
                        cmd.emit_err = 1'b1;
                    end
                    else
                    begin
                        cmd.latch  = 1'b1;
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                sel_next   = bar_pkg::DIV_FX;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DWAIT;
            end
            S_DWAIT:
            begin
                if (!stat.div_busy)
                begin
                    cmd.div_capture = 1'b1;
                    if (sel_reg == bar_pkg::DIV_FY2)
                    begin
                        state_next = S_WIN;
                    end
                    else if (sel_reg == bar_pkg::DIV_BLUE)
                    begin
                        cmd.emit   = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        sel_next   = sel_reg + bar_pkg::DIV_SEL_W'(1);
                        state_next = S_DIV;
                    end
                end
            end
            S_WIN:
            begin
                cmd.win    = 1'b1;
                state_next = S_PREP;
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = S_WALK;
            end
            S_WALK:
            begin
                cmd.walk = 1'b1;
                if (stat.walk_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                sel_next   = bar_pkg::DIV_RED;
                state_next = S_DIV;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sel_reg   <= bar_pkg::DIV_FX;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

`default_nettype wire

### rtl/core/bar_dp.sv
// ----------------------------------------------------------------------------
// bar_dp
// Datapath: size registers, frame store, window math, sums, result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module bar_dp (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire bar_pkg::bar_cmd_t               cmd,
    output bar_pkg::bar_stat_t                   stat,
    input  wire logic                            cfg_write,
    input  wire logic [bar_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [bar_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic [bar_pkg::COORD_W-1:0]     pos_col,
    input  wire logic [bar_pkg::COORD_W-1:0]     pos_row,
    input  wire logic [bar_pkg::CH_W-1:0]        in_red,
    input  wire logic [bar_pkg::CH_W-1:0]        in_green,
    input  wire logic [bar_pkg::CH_W-1:0]        in_blue,
    output logic                                 done,
    output logic [bar_pkg::CH_W-1:0]             out_red,
    output logic [bar_pkg::CH_W-1:0]             out_green,
    output logic [bar_pkg::CH_W-1:0]             out_blue,
    output logic                                 range_error
);

    logic [bar_pkg::SRC_SIZE_W-1:0] src_w_reg;
    logic [bar_pkg::SRC_SIZE_W-1:0] src_h_reg;
    logic [bar_pkg::DST_SIZE_W-1:0] dst_w_reg;
    logic [bar_pkg::DST_SIZE_W-1:0] dst_h_reg;

    logic [3*bar_pkg::CH_W-1:0] mem [bar_pkg::STORE_DEPTH];
    logic [3*bar_pkg::CH_W-1:0] rd_data_reg;
    logic                       rd_valid_reg;
    logic                       load_in_range;
    logic [bar_pkg::ADDR_W-1:0] wr_addr;
    logic [bar_pkg::ADDR_W-1:0] rd_addr;

    logic [bar_pkg::COORD_W-1:0]   col_reg;
    logic [bar_pkg::COORD_W-1:0]   row_reg;
    logic [bar_pkg::PROD_W-1:0]    p_fx_reg;
    logic [bar_pkg::PROD_W-1:0]    p_fx2_reg;
    logic [bar_pkg::PROD_W-1:0]    p_fy_reg;
    logic [bar_pkg::PROD_W-1:0]    p_fy2_reg;
    logic [bar_pkg::Q_W-1:0]       fx_reg;
    logic [bar_pkg::Q_W-1:0]       fx2_reg;
    logic [bar_pkg::Q_W-1:0]       fy_reg;
    logic [bar_pkg::Q_W-1:0]       fy2_reg;
    logic [bar_pkg::CNT_W-1:0]     cx_reg;
    logic [bar_pkg::CNT_W-1:0]     cy_reg;
    logic [bar_pkg::PIX_CNT_W-1:0] n_reg;
    logic [bar_pkg::SRC_COL_W-1:0] x_reg;
    logic [bar_pkg::SRC_ROW_W-1:0] y_reg;
    logic [bar_pkg::SRC_COL_W-1:0] last_x_reg;
    logic [bar_pkg::SRC_ROW_W-1:0] last_y_reg;
    logic [bar_pkg::SUM_W-1:0]     sum_r_reg;
    logic [bar_pkg::SUM_W-1:0]     sum_g_reg;
    logic [bar_pkg::SUM_W-1:0]     sum_b_reg;

    logic [bar_pkg::DVD_W-1:0] div_dvd;
    logic [bar_pkg::DSR_W-1:0] div_dsr;
    logic                      div_busy;
    logic [bar_pkg::Q_W-1:0]   div_q;

    logic                      done_reg;
    logic                      err_reg;
    logic [bar_pkg::CH_W-1:0]  red_reg;
    logic [bar_pkg::CH_W-1:0]  green_reg;
    logic [bar_pkg::CH_W-1:0]  blue_reg;

    // window length on one axis, edge window collapses to one pixel
    function automatic logic [bar_pkg::CNT_W-1:0] axis_count(
        input logic [bar_pkg::Q_W-1:0]        f,
        input logic [bar_pkg::Q_W-1:0]        f2,
        input logic [bar_pkg::SRC_SIZE_W-1:0] src,
        input logic [bar_pkg::DST_SIZE_W-1:0] dst
    );
        logic                          flag;
        logic [bar_pkg::Q_W:0]         c_raw;
        logic [bar_pkg::Q_W+1:0]       reach;
        logic [bar_pkg::CNT_W-1:0]     r;
        flag  = (bar_pkg::DST_SIZE_W'(src) != dst);
        c_raw = {1'b0, f2} - {1'b0, f} + (bar_pkg::Q_W + 1)'(flag);
        reach = (bar_pkg::Q_W + 2)'(f) + (bar_pkg::Q_W + 2)'(c_raw);
        if (reach >= (bar_pkg::Q_W + 2)'(src))
        begin
            r = bar_pkg::CNT_W'(1);
        end
        else
        begin
            r = bar_pkg::CNT_W'(c_raw);
        end
        return r;
    endfunction

    // size registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg <= bar_pkg::SRC_SIZE_W'(1);
            src_h_reg <= bar_pkg::SRC_SIZE_W'(1);
            dst_w_reg <= bar_pkg::DST_SIZE_W'(1);
            dst_h_reg <= bar_pkg::DST_SIZE_W'(1);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                bar_pkg::CFG_SRC_WIDTH:
                    src_w_reg <= bar_pkg::SRC_SIZE_W'(bar_pkg::clamp_size(
                        bar_pkg::CFG_DATA_W'(cfg_data[bar_pkg::SRC_SIZE_W-1:0]),
                        bar_pkg::CFG_DATA_W'(bar_pkg::MAX_SRC_WIDTH)));
                bar_pkg::CFG_SRC_HEIGHT:
                    src_h_reg <= bar_pkg::SRC_SIZE_W'(bar_pkg::clamp_size(
                        bar_pkg::CFG_DATA_W'(cfg_data[bar_pkg::SRC_SIZE_W-1:0]),
                        bar_pkg::CFG_DATA_W'(bar_pkg::MAX_SRC_HEIGHT)));
                bar_pkg::CFG_DST_WIDTH:
                    dst_w_reg <= bar_pkg::DST_SIZE_W'(bar_pkg::clamp_size(
                        cfg_data, bar_pkg::CFG_DATA_W'(bar_pkg::MAX_DST_DIM)));
                bar_pkg::CFG_DST_HEIGHT:
                    dst_h_reg <= bar_pkg::DST_SIZE_W'(bar_pkg::clamp_size(
                        cfg_data, bar_pkg::CFG_DATA_W'(bar_pkg::MAX_DST_DIM)));
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        load_in_range = (bar_pkg::DST_SIZE_W'(pos_col) < bar_pkg::DST_SIZE_W'(src_w_reg))
                     && (bar_pkg::DST_SIZE_W'(pos_row) < bar_pkg::DST_SIZE_W'(src_h_reg));
        stat.req_err  = (bar_pkg::DST_SIZE_W'(pos_col) >= dst_w_reg)
                     || (bar_pkg::DST_SIZE_W'(pos_row) >= dst_h_reg);
        wr_addr = bar_pkg::ADDR_W'(bar_pkg::ADDR_W'(pos_row[bar_pkg::SRC_ROW_W-1:0])
                  * bar_pkg::ADDR_W'(bar_pkg::MAX_SRC_WIDTH))
                  + bar_pkg::ADDR_W'(pos_col[bar_pkg::SRC_COL_W-1:0]);
        rd_addr = bar_pkg::ADDR_W'(bar_pkg::ADDR_W'(y_reg)
                  * bar_pkg::ADDR_W'(bar_pkg::MAX_SRC_WIDTH))
                  + bar_pkg::ADDR_W'(x_reg);
        stat.walk_last = (x_reg == last_x_reg) && (y_reg == last_y_reg);
        stat.div_busy  = div_busy;
    end

    // frame store
    always_ff @(posedge clk)
    begin
        if (cmd.load && load_in_range)
        begin
            mem[wr_addr] <= {in_red, in_green, in_blue};
        end
        if (cmd.walk)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // divider operand select
    always_comb
    begin
        case (cmd.div_sel)
            bar_pkg::DIV_FX:
            begin
                div_dvd = bar_pkg::DVD_W'(p_fx_reg);
                div_dsr = bar_pkg::DSR_W'(dst_w_reg);
            end
            bar_pkg::DIV_FX2:
            begin
                div_dvd = bar_pkg::DVD_W'(p_fx2_reg);
                div_dsr = bar_pkg::DSR_W'(dst_w_reg);
            end
            bar_pkg::DIV_FY:
            begin
                div_dvd = bar_pkg::DVD_W'(p_fy_reg);
                div_dsr = bar_pkg::DSR_W'(dst_h_reg);
            end
            bar_pkg::DIV_FY2:
            begin
                div_dvd = bar_pkg::DVD_W'(p_fy2_reg);
                div_dsr = bar_pkg::DSR_W'(dst_h_reg);
            end
            bar_pkg::DIV_RED:
            begin
                div_dvd = bar_pkg::DVD_W'(sum_r_reg);
                div_dsr = bar_pkg::DSR_W'(n_reg);
            end
            bar_pkg::DIV_GREEN:
            begin
                div_dvd = bar_pkg::DVD_W'(sum_g_reg);
                div_dsr = bar_pkg::DSR_W'(n_reg);
            end
            bar_pkg::DIV_BLUE:
            begin
                div_dvd = bar_pkg::DVD_W'(sum_b_reg);
                div_dsr = bar_pkg::DSR_W'(n_reg);
            end
            default:
            begin
                div_dvd = '0;
                div_dsr = bar_pkg::DSR_W'(1);
            end
        endcase
    end

    bar_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .busy     (div_busy),
        .quotient (div_q)
    );

    // window setup and walk
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            col_reg <= pos_col;
            row_reg <= pos_row;
        end
        if (cmd.mul)
        begin
            p_fx_reg  <= bar_pkg::PROD_W'(col_reg) * bar_pkg::PROD_W'(src_w_reg);
            p_fx2_reg <= (bar_pkg::PROD_W'(col_reg) + bar_pkg::PROD_W'(1))
                         * bar_pkg::PROD_W'(src_w_reg);
            p_fy_reg  <= bar_pkg::PROD_W'(row_reg) * bar_pkg::PROD_W'(src_h_reg);
            p_fy2_reg <= (bar_pkg::PROD_W'(row_reg) + bar_pkg::PROD_W'(1))
                         * bar_pkg::PROD_W'(src_h_reg);
        end
        if (cmd.div_capture)
        begin
            case (cmd.div_sel)
                bar_pkg::DIV_FX:  fx_reg  <= div_q;
                bar_pkg::DIV_FX2: fx2_reg <= div_q;
                bar_pkg::DIV_FY:  fy_reg  <= div_q;
                bar_pkg::DIV_FY2: fy2_reg <= div_q;
                default:
                begin
                end
            endcase
        end
        if (cmd.win)
        begin
            cx_reg <= axis_count(fx_reg, fx2_reg, src_w_reg, dst_w_reg);
            cy_reg <= axis_count(fy_reg, fy2_reg, src_h_reg, dst_h_reg);
        end
        if (cmd.prep)
        begin
            n_reg      <= bar_pkg::PIX_CNT_W'(cx_reg) * bar_pkg::PIX_CNT_W'(cy_reg);
            last_x_reg <= bar_pkg::SRC_COL_W'(fx_reg + bar_pkg::Q_W'(cx_reg)
                          - bar_pkg::Q_W'(1));
            last_y_reg <= bar_pkg::SRC_ROW_W'(fy_reg + bar_pkg::Q_W'(cy_reg)
                          - bar_pkg::Q_W'(1));
            x_reg      <= fx_reg[bar_pkg::SRC_COL_W-1:0];
            y_reg      <= fy_reg[bar_pkg::SRC_ROW_W-1:0];
            sum_r_reg  <= '0;
            sum_g_reg  <= '0;
            sum_b_reg  <= '0;
        end
        else
        begin
            if (cmd.walk)
            begin
                if (x_reg == last_x_reg)
                begin
                    x_reg <= fx_reg[bar_pkg::SRC_COL_W-1:0];
                    y_reg <= y_reg + bar_pkg::SRC_ROW_W'(1);
                end
                else
                begin
                    x_reg <= x_reg + bar_pkg::SRC_COL_W'(1);
                end
            end
            if (rd_valid_reg)
            begin
                sum_r_reg <= sum_r_reg + bar_pkg::SUM_W'(rd_data_reg[3*bar_pkg::CH_W-1:
                                                                     2*bar_pkg::CH_W]);
                sum_g_reg <= sum_g_reg + bar_pkg::SUM_W'(rd_data_reg[2*bar_pkg::CH_W-1:
                                                                     bar_pkg::CH_W]);
                sum_b_reg <= sum_b_reg + bar_pkg::SUM_W'(rd_data_reg[bar_pkg::CH_W-1:0]);
            end
        end
    end

    // result registers
    always_ff @(posedge clk)
    begin
        if (cmd.emit_err)
        begin
            red_reg   <= '0;
            green_reg <= '0;
            blue_reg  <= '0;
        end
        else if (cmd.div_capture)
        begin
            case (cmd.div_sel)
                bar_pkg::DIV_RED:   red_reg   <= div_q[bar_pkg::CH_W-1:0];
                bar_pkg::DIV_GREEN: green_reg <= div_q[bar_pkg::CH_W-1:0];
                bar_pkg::DIV_BLUE:  blue_reg  <= div_q[bar_pkg::CH_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
            err_reg      <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.walk;
            done_reg     <= cmd.emit | cmd.emit_err;
            if (cmd.emit_err)
            begin
                err_reg <= 1'b1;
            end
            else if (cmd.emit)
            begin
                err_reg <= 1'b0;
            end
        end
    end

    assign done        = done_reg;
    assign range_error = err_reg;
    assign out_red     = red_reg;
    assign out_green   = green_reg;
    assign out_blue    = blue_reg;

endmodule

`default_nettype wire

### rtl/core/bar_checker.sv
// ----------------------------------------------------------------------------
// bar_checker
// Port-level checks of the resampler core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bar_checker (
    input wire logic                     clk,
    input wire logic                     rst_n,
    input wire logic                     start,
    input wire logic                     busy,
    input wire logic                     func,
    input wire logic                     done,
    input wire logic [bar_pkg::CH_W-1:0] out_red,
    input wire logic [bar_pkg::CH_W-1:0] out_green,
    input wire logic [bar_pkg::CH_W-1:0] out_blue,
    input wire logic                     range_error
);

    // a result is only shown once the block is free again
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    // out-of-range result carries zero colour
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && range_error) |-> (out_red == '0 && out_green == '0 && out_blue == '0))
        else $error("range error with nonzero colour");

    // a request transfer is followed by work or an immediate result
    a_req_reacts: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && func == bar_pkg::FUNC_REQUEST) |=> (busy || done))
        else $error("request ignored");

    // a load transfer neither raises busy nor makes a result
    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && func == bar_pkg::FUNC_LOAD) |=> (!busy && !done))
        else $error("load produced activity");

    // finishing a request always delivers its result
    a_finish_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without result");

endmodule

bind box_average_image_resampler_core bar_checker u_bar_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .func        (func),
    .done        (done),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue),
    .range_error (range_error)
);

`default_nettype wire

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the box-average image resampler core.
// ----------------------------------------------------------------------------
// Loads source pixels and requests destination pixels through the start/busy
// command port, under a series of source and target sizes: reset sizes,
// register extremes, equal sizes, back-to-back transfers, strips and random up
// and down scaling. A predictor keeps its own copy of the frame store and
// sizes and works out each box average; every done strobe is compared field
// by field with the oldest expected pixel. Requests are only made where every
// source pixel of the window has been loaded.
// ----------------------------------------------------------------------------
module tb_top;

    typedef struct packed {
        logic [bar_pkg::CH_W-1:0] red;
        logic [bar_pkg::CH_W-1:0] green;
        logic [bar_pkg::CH_W-1:0] blue;
        logic                     err;
    } pixel_result_t;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            start;
    logic                            busy;
    logic                            func;
    logic [bar_pkg::COORD_W-1:0]     pos_col;
    logic [bar_pkg::COORD_W-1:0]     pos_row;
    logic [bar_pkg::CH_W-1:0]        in_red;
    logic [bar_pkg::CH_W-1:0]        in_green;
    logic [bar_pkg::CH_W-1:0]        in_blue;
    logic                            cfg_write;
    logic [bar_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [bar_pkg::CFG_DATA_W-1:0]  cfg_data;
    logic                            done;
    logic [bar_pkg::CH_W-1:0]        out_red;
    logic [bar_pkg::CH_W-1:0]        out_green;
    logic [bar_pkg::CH_W-1:0]        out_blue;
    logic                            range_error;

    // predictor state
    logic [3*bar_pkg::CH_W-1:0] frame_copy [0:bar_pkg::STORE_DEPTH-1];
    bit                         frame_written [0:bar_pkg::STORE_DEPTH-1];
    int unsigned                src_w;
    int unsigned                src_h;
    int unsigned                dst_w;
    int unsigned                dst_h;
    pixel_result_t              expected_pixels [$];

    int unsigned fail_count;
    int unsigned load_count;
    int unsigned request_count;
    int unsigned miss_count;
    int unsigned setting_count;
    int unsigned items_total;
    bit          gaps_on;

    box_average_image_resampler_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .func        (func),
        .pos_col     (pos_col),
        .pos_row     (pos_row),
        .in_red      (in_red),
        .in_green    (in_green),
        .in_blue     (in_blue),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .done        (done),
        .out_red     (out_red),
        .out_green   (out_green),
        .out_blue    (out_blue),
        .range_error (range_error)
    );

    always #5 clk = ~clk;

    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned limit);
        if (v == 0)
        begin
            return 1;
        end
        if (v > limit)
        begin
            return limit;
        end
        return v;
    endfunction

    function automatic void apply_reg(input logic [bar_pkg::CFG_INDEX_W-1:0] idx,
                                      input logic [bar_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            bar_pkg::CFG_SRC_WIDTH:
                src_w = clamp_dim(data[bar_pkg::SRC_SIZE_W-1:0], bar_pkg::MAX_SRC_WIDTH);
            bar_pkg::CFG_SRC_HEIGHT:
                src_h = clamp_dim(data[bar_pkg::SRC_SIZE_W-1:0], bar_pkg::MAX_SRC_HEIGHT);
            bar_pkg::CFG_DST_WIDTH:
                dst_w = clamp_dim(data[bar_pkg::DST_SIZE_W-1:0], bar_pkg::MAX_DST_DIM);
            bar_pkg::CFG_DST_HEIGHT:
                dst_h = clamp_dim(data[bar_pkg::DST_SIZE_W-1:0], bar_pkg::MAX_DST_DIM);
            default: ;
        endcase
    endfunction

    // source window on one axis; edge windows collapse to one pixel
    function automatic void axis_span(input int unsigned d, input int unsigned s,
                                      input int unsigned t, output int unsigned first,
                                      output int unsigned cnt);
        int unsigned flag;
        flag  = (s == t) ? 0 : 1;
        first = d * s / t;
        cnt   = (d + 1) * s / t - first + flag;
        if (first + cnt >= s)
        begin
            cnt = 1;
        end
    endfunction

    function automatic void store_pixel(input int unsigned col, input int unsigned row,
                                        input logic [3*bar_pkg::CH_W-1:0] px);
        if (col < src_w && row < src_h)
        begin
            frame_copy[row * bar_pkg::MAX_SRC_WIDTH + col]    = px;
            frame_written[row * bar_pkg::MAX_SRC_WIDTH + col] = 1'b1;
        end
    endfunction

    function automatic pixel_result_t predict_pixel(input int unsigned col,
                                                    input int unsigned row);
        pixel_result_t              res;
        int unsigned                fx, cx, fy, cy, n, sr, sg, sb;
        logic [3*bar_pkg::CH_W-1:0] px;
        res = '0;
        if (col >= dst_w || row >= dst_h)
        begin
            res.err = 1'b1;
            return res;
        end
        axis_span(col, src_w, dst_w, fx, cx);
        axis_span(row, src_h, dst_h, fy, cy);
        sr = 0;
        sg = 0;
        sb = 0;
        for (int unsigned y = fy; y < fy + cy; y++)
        begin
            for (int unsigned x = fx; x < fx + cx; x++)
            begin
                px = frame_copy[y * bar_pkg::MAX_SRC_WIDTH + x];
                sr += px[3*bar_pkg::CH_W-1:2*bar_pkg::CH_W];
                sg += px[2*bar_pkg::CH_W-1:bar_pkg::CH_W];
                sb += px[bar_pkg::CH_W-1:0];
            end
        end
        n = cx * cy;
        if (n == 0)
        begin
            n = 1;
        end
        res.red   = bar_pkg::CH_W'(sr / n);
        res.green = bar_pkg::CH_W'(sg / n);
        res.blue  = bar_pkg::CH_W'(sb / n);
        return res;
    endfunction

    // true when every source pixel under the window has been loaded
    function automatic bit window_written(input int unsigned col, input int unsigned row);
        int unsigned fx, cx, fy, cy;
        if (col >= dst_w || row >= dst_h)
        begin
            return 1'b1;
        end
        axis_span(col, src_w, dst_w, fx, cx);
        axis_span(row, src_h, dst_h, fy, cy);
        for (int unsigned y = fy; y < fy + cy; y++)
        begin
            for (int unsigned x = fx; x < fx + cx; x++)
            begin
                if (!frame_written[y * bar_pkg::MAX_SRC_WIDTH + x])
                begin
                    return 1'b0;
                end
            end
        end
        return 1'b1;
    endfunction

    // result check and transfer capture
    always @(posedge clk)
    begin
        pixel_result_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $error("result with no pixel expected");
                    fail_count++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (out_red !== want.red)
                    begin
                        $error("out_red expected %0d got %0d", want.red, out_red);
                        fail_count++;
                    end
                    if (out_green !== want.green)
                    begin
                        $error("out_green expected %0d got %0d", want.green, out_green);
                        fail_count++;
                    end
                    if (out_blue !== want.blue)
                    begin
                        $error("out_blue expected %0d got %0d", want.blue, out_blue);
                        fail_count++;
                    end
                    if (range_error !== want.err)
                    begin
                        $error("range_error expected %0d got %0d", want.err, range_error);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                if (func == bar_pkg::FUNC_LOAD)
                begin
                    load_count++;
                    store_pixel(pos_col, pos_row, {in_red, in_green, in_blue});
                end
                else
                begin
                    request_count++;
                    want = predict_pixel(pos_col, pos_row);
                    if (want.err)
                    begin
                        miss_count++;
                    end
                    expected_pixels.push_back(want);
                end
            end
        end
    end

    task automatic send_item(input logic f, input int unsigned col, input int unsigned row,
                             input logic [bar_pkg::CH_W-1:0] r,
                             input logic [bar_pkg::CH_W-1:0] g,
                             input logic [bar_pkg::CH_W-1:0] b);
        int unsigned gap;
        if (gaps_on && $urandom_range(0, 99) < 16)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 120) : $urandom_range(1, 3);
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start    <= 1'b1;
        func     <= f;
        pos_col  <= bar_pkg::COORD_W'(col);
        pos_row  <= bar_pkg::COORD_W'(row);
        in_red   <= r;
        in_green <= g;
        in_blue  <= b;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic send_load(input int unsigned col, input int unsigned row);
        send_item(bar_pkg::FUNC_LOAD, col, row, bar_pkg::CH_W'($urandom),
                  bar_pkg::CH_W'($urandom), bar_pkg::CH_W'($urandom));
    endtask

    task automatic send_request(input int unsigned col, input int unsigned row);
        send_item(bar_pkg::FUNC_REQUEST, col, row, bar_pkg::CH_W'($urandom),
                  bar_pkg::CH_W'($urandom), bar_pkg::CH_W'($urandom));
    endtask

    task automatic wait_results_drained();
        @(negedge clk);
        start <= 1'b0;
        while (expected_pixels.size() != 0 || busy) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [bar_pkg::CFG_INDEX_W-1:0] idx,
                             input int unsigned data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= bar_pkg::CFG_DATA_W'(data);
        @(posedge clk);
        apply_reg(idx, bar_pkg::CFG_DATA_W'(data));
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic set_sizes(input int unsigned sw, input int unsigned sh,
                             input int unsigned tw, input int unsigned th);
        wait_results_drained();
        write_reg(bar_pkg::CFG_SRC_WIDTH, sw);
        write_reg(bar_pkg::CFG_SRC_HEIGHT, sh);
        write_reg(bar_pkg::CFG_DST_WIDTH, tw);
        write_reg(bar_pkg::CFG_DST_HEIGHT, th);
        setting_count++;
    endtask

    // request outside the target, or a load when the target covers every coordinate
    task automatic send_range_miss(input int unsigned fill_w, input int unsigned fill_h);
        if (dst_w < bar_pkg::MAX_DST_DIM
            && (dst_h == bar_pkg::MAX_DST_DIM || $urandom_range(0, 1) == 1))
        begin
            send_request($urandom_range(dst_w, 1023), $urandom_range(0, 1023));
        end
        else if (dst_h < bar_pkg::MAX_DST_DIM)
        begin
            send_request($urandom_range(0, 1023), $urandom_range(dst_h, 1023));
        end
        else
        begin
            send_load($urandom_range(0, fill_w - 1), $urandom_range(0, fill_h - 1));
        end
    endtask

    task automatic run_phase(input int unsigned sw, input int unsigned sh,
                             input int unsigned tw, input int unsigned th,
                             input int unsigned n_items);
        int unsigned fill_w, fill_h, col_top, row_top, col, row, pick, tries, sent;
        bit          found;
        set_sizes(sw, sh, tw, th);
        fill_w = (src_w * src_h <= 1024 || src_w < 16) ? src_w : 16;
        fill_h = (src_w * src_h <= 1024 || src_h < 16) ? src_h : 16;
        for (int unsigned r = 0; r < fill_h; r++)
        begin
            for (int unsigned c = 0; c < fill_w; c++)
            begin
                send_load(c, r);
            end
        end
        sent = fill_w * fill_h;
        col_top = dst_w - 1;
        if (fill_w < src_w && fill_w * dst_w / src_w < col_top)
        begin
            col_top = fill_w * dst_w / src_w;
        end
        row_top = dst_h - 1;
        if (fill_h < src_h && fill_h * dst_h / src_h < row_top)
        begin
            row_top = fill_h * dst_h / src_h;
        end
        for (int unsigned i = 0; i < n_items; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 3)
            begin
                wait_results_drained();
            end
            else if (pick < 70)
            begin
                found = 1'b0;
                tries = 0;
                while (!found && tries < 8)
                begin
                    col   = $urandom_range(0, col_top);
                    row   = $urandom_range(0, row_top);
                    found = window_written(col, row);
                    tries++;
                end
                if (found)
                begin
                    send_request(col, row);
                end
                else
                begin
                    send_range_miss(fill_w, fill_h);
                end
                sent++;
            end
            else if (pick < 82)
            begin
                send_load($urandom_range(0, src_w - 1), $urandom_range(0, src_h - 1));
                sent++;
            end
            else if (pick < 91)
            begin
                send_range_miss(fill_w, fill_h);
                sent++;
            end
            else if ($urandom_range(0, 1) == 1)
            begin
                send_load($urandom_range(src_w, 1023), $urandom_range(0, 1023));
                sent++;
            end
            else
            begin
                send_load($urandom_range(0, 1023), $urandom_range(src_h, 1023));
                sent++;
            end
        end
        items_total += sent;
    endtask

    task automatic test_reset_sizes();
        send_item(bar_pkg::FUNC_LOAD, 0, 0, 8'hFF, 8'hFF, 8'hFF);
        send_request(0, 0);
        send_item(bar_pkg::FUNC_LOAD, 1, 0, 8'h00, 8'h00, 8'h00);
        send_item(bar_pkg::FUNC_LOAD, 0, 1, 8'h00, 8'h00, 8'h00);
        send_item(bar_pkg::FUNC_LOAD, 1023, 1023, 8'h00, 8'h00, 8'h00);
        send_request(0, 0);
        send_request(1, 0);
        send_request(0, 1);
        send_request(1023, 1023);
        send_item(bar_pkg::FUNC_LOAD, 0, 0, 8'hA5, 8'h5A, 8'h3C);
        send_request(0, 0);
    endtask

    task automatic test_register_extremes();
        // zero and out-of-mask writes fall back to one, all ones saturates
        set_sizes(11'h200, 0, 0, 11'h7FF);
        send_request(0, 0);
        send_request(0, 1023);
        send_request(1, 0);
        set_sizes(511, 511, 11'h7FF, 11'h7FF);
        send_item(bar_pkg::FUNC_LOAD, 254, 254, 8'h00, 8'hFF, 8'h80);
        send_item(bar_pkg::FUNC_LOAD, 255, 254, 8'hFF, 8'h00, 8'h7F);
        send_item(bar_pkg::FUNC_LOAD, 254, 255, 8'h01, 8'hFE, 8'h55);
        send_item(bar_pkg::FUNC_LOAD, 255, 255, 8'hFE, 8'h01, 8'hAA);
        send_request(1023, 1023);
        send_request(1020, 1022);
        send_request(1016, 1020);
        send_request(0, 0);
        set_sizes(256, 256, 1024, 1024);
        send_request(1023, 1023);
    endtask

    task automatic test_equal_sizes();
        run_phase(8, 8, 8, 8, 40);
        run_phase(24, 5, 24, 5, 30);
    endtask

    task automatic test_back_to_back();
        gaps_on = 1'b0;
        run_phase(16, 16, 4, 4, 150);
        gaps_on = 1'b1;
    endtask

    task automatic test_strips();
        run_phase(256, 1, $urandom_range(1, 1024), $urandom_range(1, 4), 60);
        run_phase(1, 256, $urandom_range(1, 4), $urandom_range(1, 1024), 60);
    endtask

    task automatic test_random_scaling();
        int unsigned kind, sw, sh, tw, th;
        while (items_total < 1850)
        begin
            kind = $urandom_range(0, 4);
            case (kind)
                0:
                begin
                    sw = $urandom_range(2, 16);
                    sh = $urandom_range(2, 16);
                    tw = $urandom_range(1, sw);
                    th = $urandom_range(1, sh);
                end
                1:
                begin
                    sw = $urandom_range(1, 10);
                    sh = $urandom_range(1, 10);
                    tw = $urandom_range(sw, 96);
                    th = $urandom_range(sh, 96);
                end
                2:
                begin
                    sw = $urandom_range(1, 20);
                    sh = $urandom_range(1, 20);
                    tw = sw;
                    th = sh;
                end
                3:
                begin
                    sw = $urandom_range(1, 24);
                    sh = $urandom_range(1, 24);
                    tw = $urandom_range(1, 64);
                    th = $urandom_range(1, 64);
                end
                default:
                begin
                    sw = $urandom_range(0, 511);
                    sh = $urandom_range(0, 511);
                    tw = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 2047)
                                                     : $urandom_range(256, 2047);
                    th = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 2047)
                                                     : $urandom_range(256, 2047);
                end
            endcase
            run_phase(sw, sh, tw, th, $urandom_range(60, 140));
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        start         = 1'b0;
        func          = bar_pkg::FUNC_LOAD;
        pos_col       = '0;
        pos_row       = '0;
        in_red        = '0;
        in_green      = '0;
        in_blue       = '0;
        cfg_write     = 1'b0;
        cfg_index     = bar_pkg::CFG_SRC_WIDTH;
        cfg_data      = '0;
        src_w         = 1;
        src_h         = 1;
        dst_w         = 1;
        dst_h         = 1;
        fail_count    = 0;
        load_count    = 0;
        request_count = 0;
        miss_count    = 0;
        setting_count = 0;
        items_total   = 0;
        gaps_on       = 1'b1;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        test_reset_sizes();
        test_register_extremes();
        test_equal_sizes();
        test_back_to_back();
        test_strips();
        test_random_scaling();

        wait_results_drained();
        repeat (20) @(negedge clk);
        $display("covered %0d load and %0d request transfers (%0d outside the target)",
                 load_count, request_count, miss_count);
        $display("over %0d size settings", setting_count);
        if (fail_count == 0 && expected_pixels.size() == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

    initial
    begin
        #100_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

### sim.f
rtl/core/bar_pkg.sv
rtl/core/bar_div.sv
rtl/core/bar_ctrl.sv
rtl/core/bar_dp.sv
rtl/core/box_average_image_resampler_core.sv
rtl/core/bar_checker.sv
sim/tb_top.sv
